// ----- rtl/core/ddsv_pkg.sv -----
package ddsv_pkg;

  // byte counter width, saturating at all ones
  localparam int COUNT_BITS = 40;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  localparam int BYTE_W  = 8;
  localparam int WORD_W  = 32;
  localparam int FMT_W   = 2;
  localparam int HDR_BYTES = 128;

  // bit width of the widest row size in bytes: ceil(width/4) blocks of 16 bytes
  localparam int ROW_W = 35;

  // header word slots
  localparam int H_SIZE    = 0;
  localparam int H_FLAGS   = 1;
  localparam int H_HEIGHT  = 2;
  localparam int H_WIDTH   = 3;
  localparam int H_PITCH   = 4;
  localparam int H_PFSIZE  = 5;
  localparam int H_PFFLAGS = 6;
  localparam int H_FOURCC  = 7;
  localparam int H_BITS    = 8;
  localparam int H_RMASK   = 9;
  localparam int H_GMASK   = 10;
  localparam int H_BMASK   = 11;
  localparam int H_AMASK   = 12;
  localparam int H_CAPS    = 13;
  localparam int H_NUM     = 14;
  localparam int SLOT_W    = 4;

  // file word positions of the kept header words
  localparam logic [4:0] WORD_MAGIC     = 5'd0;
  localparam logic [4:0] WORD_HDR_FIRST = 5'd1;
  localparam logic [4:0] WORD_HDR_LAST  = 5'd5;
  localparam logic [4:0] WORD_PF_FIRST  = 5'd19;
  localparam logic [4:0] WORD_PF_LAST   = 5'd27;

  localparam logic [WORD_W-1:0] MAGIC_WORD   = 32'h2053_4444;
  localparam logic [WORD_W-1:0] FCC_DXT1     = 32'h3154_5844;
  localparam logic [WORD_W-1:0] FCC_DXT3     = 32'h3354_5844;
  localparam logic [WORD_W-1:0] FCC_DXT5     = 32'h3554_5844;
  localparam logic [WORD_W-1:0] HDR_SIZE     = 32'd124;
  localparam logic [WORD_W-1:0] PF_SIZE      = 32'd32;
  localparam logic [WORD_W-1:0] FLAGS_NEED   = 32'h0000_1007;
  localparam logic [WORD_W-1:0] FLAG_PITCH   = 32'h0000_0008;
  localparam logic [WORD_W-1:0] FLAG_LINEAR  = 32'h0008_0000;
  localparam logic [WORD_W-1:0] CAPS_TEXTURE = 32'h0000_1000;
  localparam logic [WORD_W-1:0] PF_FOURCC    = 32'h0000_0004;
  localparam logic [WORD_W-1:0] PF_ARGB      = 32'h0000_0041;
  localparam logic [WORD_W-1:0] ARGB_BITS    = 32'd32;
  localparam logic [WORD_W-1:0] MASK_R       = 32'h00FF_0000;
  localparam logic [WORD_W-1:0] MASK_G       = 32'h0000_FF00;
  localparam logic [WORD_W-1:0] MASK_B       = 32'h0000_00FF;
  localparam logic [WORD_W-1:0] MASK_A       = 32'hFF00_0000;
  localparam logic [WORD_W-1:0] ARGB_MAX_W   = 32'h3FFF_FFFF;

  typedef enum logic [FMT_W-1:0] {
    FMT_DXT1 = 2'd0,
    FMT_DXT3 = 2'd1,
    FMT_DXT5 = 2'd2,
    FMT_ARGB = 2'd3
  } fmt_t;

endpackage

// ----- rtl/core/ddsv_in_if.sv -----
interface ddsv_in_if;
  logic                         valid;
  logic                         ready;
  logic [ddsv_pkg::BYTE_W-1:0]  data_byte;
  logic                         last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ----- rtl/core/ddsv_out_if.sv -----
interface ddsv_out_if;
  logic                         valid;
  logic                         ready;
  logic                         accepted;
  logic [ddsv_pkg::FMT_W-1:0]   format_code;
  logic [ddsv_pkg::WORD_W-1:0]  image_width;
  logic [ddsv_pkg::WORD_W-1:0]  image_height;

  modport source (output valid, output accepted, output format_code,
                  output image_width, output image_height, input ready);
  modport sink   (input valid, input accepted, input format_code,
                  input image_width, input image_height, output ready);
endinterface

// ----- rtl/core/dds_texture_header_validator.sv -----
// Texture header validator: takes one file byte per beat and reports one
// verdict beat after the beat flagged last_byte. Each byte passes an input
// register and then the result register. The verdict beat is registered as
// the last byte leaves the input register, and a byte can be taken in
// every cycle. The only stall is a finished verdict that the result side
// has not yet taken while the next file's last byte arrives. The payload
// length is checked without a multiplier: payload bytes are tallied as
// (row, column) against the row size decoded from the header, and the
// verdict needs column zero and the row count equal to the expected rows.
module dds_texture_header_validator (
  input  logic       clk,
  input  logic       rst,
  ddsv_in_if.sink    byte_stream,
  ddsv_out_if.source report
);

  localparam int CW = ddsv_pkg::COUNT_BITS;
  localparam int RW = ddsv_pkg::ROW_W;
  localparam int WW = ddsv_pkg::WORD_W;

  // input stage
  logic                        s1_valid;
  logic [ddsv_pkg::BYTE_W-1:0] s1_byte;
  logic                        s1_last;
  logic                        s1_adv;
  logic                        s1_fire;
  logic                        out_free;

  // per-file state
  logic [CW-1:0] cnt;
  logic [WW-1:0] asm_word;
  logic [WW-1:0] hdr [ddsv_pkg::H_NUM];
  logic          magic_ok;
  logic [RW-1:0] col;
  logic [CW-1:0] row;

  // header decode, registered
  logic                 hdr_ok;
  logic                 is_argb;
  ddsv_pkg::fmt_t       fmt;
  logic [RW-1:0]        bpr;
  logic [WW-1:0]        rows_need;

  // datapath
  logic [CW-1:0]     cnt_next;
  logic [WW-1:0]     asm_next;
  logic [4:0]        word_idx;
  logic              in_hdr;
  logic              word_done;
  logic              in_payload;
  logic [RW-1:0]     col_inc;
  logic              row_wrap;
  logic [RW-1:0]     col_next;
  logic [CW-1:0]     row_next;
  logic [CW-1:0]     pay_len;
  logic              verdict;

  // header decode comb
  logic                 hdr_ok_next;
  logic                 is_argb_next;
  ddsv_pkg::fmt_t       fmt_next;
  logic [RW-1:0]        bpr_next;
  logic [WW-1:0]        rows_need_next;
  logic                 base_ok;
  logic                 argb_pf;
  logic [WW:0]          w_plus;
  logic [WW:0]          h_plus;

  // handshake
  assign out_free          = !report.valid || report.ready;
  assign s1_adv            = !s1_valid || !s1_last || out_free;
  assign s1_fire           = s1_valid && s1_adv;
  assign byte_stream.ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (byte_stream.ready) begin
      s1_valid <= byte_stream.valid;
    end
    if (byte_stream.ready) begin
      s1_byte <= byte_stream.data_byte;
      s1_last <= byte_stream.last_byte;
    end
  end

  // byte position and header word capture
  assign cnt_next  = (cnt == ddsv_pkg::COUNT_MAX) ? cnt : cnt + CW'(1);
  assign asm_next  = {s1_byte, asm_word[WW-1:ddsv_pkg::BYTE_W]};
  assign in_hdr    = (cnt[CW-1:7] == '0);
  assign word_idx  = cnt[6:2];
  assign word_done = in_hdr && (cnt[1:0] == 2'b11);
  assign in_payload = !in_hdr;

  // payload tally as rows of bpr bytes
  assign col_inc  = col + RW'(1);
  assign row_wrap = (col_inc == bpr);
  assign col_next = in_payload ? (row_wrap ? '0 : col_inc) : col;
  assign row_next = in_payload ? row + CW'(row_wrap) : row;
  assign pay_len  = cnt_next - CW'(ddsv_pkg::HDR_BYTES);

  assign verdict = hdr_ok && magic_ok
                && (cnt_next[CW-1:7] != '0)
                && (cnt_next != ddsv_pkg::COUNT_MAX)
                && (col_next == '0)
                && (row_next == CW'(rows_need))
                && (is_argb || (pay_len == CW'(hdr[ddsv_pkg::H_PITCH])));

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      magic_ok <= 1'b0;
      col      <= '0;
      row      <= '0;
    end else if (s1_fire) begin
      if (s1_last) begin
        cnt      <= '0;
        magic_ok <= 1'b0;
        col      <= '0;
        row      <= '0;
      end else begin
        cnt <= cnt_next;
        col <= col_next;
        row <= row_next;
        if (word_done && word_idx == ddsv_pkg::WORD_MAGIC) begin
          magic_ok <= (asm_next == ddsv_pkg::MAGIC_WORD);
        end
      end
    end
  end

  // header words: every kept word is rewritten before it is used
  always_ff @(posedge clk) begin
    if (s1_fire && in_hdr) begin
      asm_word <= asm_next;
    end
    if (s1_fire && word_done) begin
      if (word_idx >= ddsv_pkg::WORD_HDR_FIRST && word_idx <= ddsv_pkg::WORD_HDR_LAST) begin
        hdr[ddsv_pkg::SLOT_W'(word_idx - ddsv_pkg::WORD_HDR_FIRST)] <= asm_next;
      end else if (word_idx >= ddsv_pkg::WORD_PF_FIRST
                   && word_idx <= ddsv_pkg::WORD_PF_LAST) begin
        hdr[ddsv_pkg::SLOT_W'(word_idx - ddsv_pkg::WORD_PF_FIRST)
            + ddsv_pkg::SLOT_W'(ddsv_pkg::H_PFSIZE)] <= asm_next;
      end
    end
  end

  // static header checks and row geometry
  always_comb begin
    w_plus = {1'b0, hdr[ddsv_pkg::H_WIDTH]} + (WW+1)'(3);
    h_plus = {1'b0, hdr[ddsv_pkg::H_HEIGHT]} + (WW+1)'(3);
    base_ok = (hdr[ddsv_pkg::H_SIZE] == ddsv_pkg::HDR_SIZE)
           && (hdr[ddsv_pkg::H_PFSIZE] == ddsv_pkg::PF_SIZE)
           && (hdr[ddsv_pkg::H_WIDTH] != '0)
           && (hdr[ddsv_pkg::H_HEIGHT] != '0)
           && ((hdr[ddsv_pkg::H_FLAGS] & ddsv_pkg::FLAGS_NEED) == ddsv_pkg::FLAGS_NEED)
           && ((hdr[ddsv_pkg::H_CAPS] & ddsv_pkg::CAPS_TEXTURE) != '0);
    argb_pf = (hdr[ddsv_pkg::H_PFFLAGS] == ddsv_pkg::PF_ARGB)
           && (hdr[ddsv_pkg::H_FOURCC] == '0)
           && (hdr[ddsv_pkg::H_BITS] == ddsv_pkg::ARGB_BITS)
           && (hdr[ddsv_pkg::H_RMASK] == ddsv_pkg::MASK_R)
           && (hdr[ddsv_pkg::H_GMASK] == ddsv_pkg::MASK_G)
           && (hdr[ddsv_pkg::H_BMASK] == ddsv_pkg::MASK_B)
           && (hdr[ddsv_pkg::H_AMASK] == ddsv_pkg::MASK_A);
    hdr_ok_next    = 1'b0;
    is_argb_next   = 1'b0;
    fmt_next       = ddsv_pkg::FMT_DXT1;
    bpr_next       = {w_plus[WW:2], 4'b0000};
    rows_need_next = {1'b0, h_plus[WW:2]};
    if (hdr[ddsv_pkg::H_PFFLAGS] == ddsv_pkg::PF_FOURCC) begin
      hdr_ok_next = base_ok && ((hdr[ddsv_pkg::H_FLAGS] & ddsv_pkg::FLAG_LINEAR) != '0);
      if (hdr[ddsv_pkg::H_FOURCC] == ddsv_pkg::FCC_DXT1) begin
        fmt_next = ddsv_pkg::FMT_DXT1;
        bpr_next = {1'b0, w_plus[WW:2], 3'b000};
      end else if (hdr[ddsv_pkg::H_FOURCC] == ddsv_pkg::FCC_DXT3) begin
        fmt_next = ddsv_pkg::FMT_DXT3;
      end else if (hdr[ddsv_pkg::H_FOURCC] == ddsv_pkg::FCC_DXT5) begin
        fmt_next = ddsv_pkg::FMT_DXT5;
      end else begin
        hdr_ok_next = 1'b0;
      end
    end else if (argb_pf) begin
      is_argb_next   = 1'b1;
      fmt_next       = ddsv_pkg::FMT_ARGB;
      bpr_next       = RW'(hdr[ddsv_pkg::H_PITCH]);
      rows_need_next = hdr[ddsv_pkg::H_HEIGHT];
      hdr_ok_next = base_ok
                 && ((hdr[ddsv_pkg::H_FLAGS] & ddsv_pkg::FLAG_PITCH) != '0)
                 && (hdr[ddsv_pkg::H_WIDTH] <= ddsv_pkg::ARGB_MAX_W)
                 && (hdr[ddsv_pkg::H_PITCH] == {hdr[ddsv_pkg::H_WIDTH][WW-3:0], 2'b00});
    end
  end

  always_ff @(posedge clk) begin
    hdr_ok    <= hdr_ok_next;
    is_argb   <= is_argb_next;
    fmt       <= fmt_next;
    bpr       <= bpr_next;
    rows_need <= rows_need_next;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      report.valid <= 1'b0;
    end else if (s1_fire && s1_last) begin
      report.valid <= 1'b1;
    end else if (report.ready) begin
      report.valid <= 1'b0;
    end
    if (s1_fire && s1_last) begin
      report.accepted     <= verdict;
      report.format_code  <= verdict ? ddsv_pkg::FMT_W'(fmt) : '0;
      report.image_width  <= verdict ? hdr[ddsv_pkg::H_WIDTH] : '0;
      report.image_height <= verdict ? hdr[ddsv_pkg::H_HEIGHT] : '0;
    end
  end

  // a rejected file reports zero fields
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    report.valid && !report.accepted |->
      report.format_code == '0 && report.image_width == '0 && report.image_height == '0)
    else $error("rejected verdict with nonzero fields");

  // a last beat leaves the stage only into a free result register
  a_last_lands: assert property (@(posedge clk) disable iff (rst)
    s1_fire && s1_last |=> report.valid)
    else $error("verdict beat lost");

  // payload column stays inside the row
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    cnt > CW'(ddsv_pkg::HDR_BYTES) && bpr != '0 && $stable(bpr) |-> col < bpr)
    else $error("payload column past row size");

endmodule
